### design/matrix_inverse_4x4_macros.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX_INVERSE_4X4_MACROS_SVH
`define MATRIX_INVERSE_4X4_MACROS_SVH

// Implication checked on every rising clock edge, disabled during reset.
`define MI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mi4_pkg.sv
//------------------------------------------------------------------------------
// mi4_pkg
// Shared widths, cofactor term table and arithmetic helpers.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package mi4_pkg;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int IW = 4;
  localparam int QDEPTH = 2;
  localparam int QPW = 1;
  // reciprocal divider width: numerator 2^(2*FB) needs 2*FB+1 bits, NW is one bit wider
  localparam int NW = 2 * FB + 2;

  typedef logic signed [EW-1:0] val_t;
  typedef logic [IW-1:0] idx_t;

  // Run command from the front to the back
  typedef struct packed {
    logic dummy;
  } run_cmd_t;

  // Maps (entry, term, factor) to a store index: 16*6*3 entries.
  function automatic idx_t cof_idx(input logic [3:0] e, input logic [2:0] t,
                                   input logic [1:0] f);
    logic [11:0] tr [0:5];
    logic [11:0] row;
    begin
      tr[0] = 12'h0; tr[1] = 12'h0; tr[2] = 12'h0;
      tr[3] = 12'h0; tr[4] = 12'h0; tr[5] = 12'h0;
      case (e)
        4'd0: begin tr[0]=12'h5af; tr[1]=12'h5be; tr[2]=12'h96f; tr[3]=12'h97e;
          tr[4]=12'hd6b; tr[5]=12'hd7a; end
        4'd1: begin tr[0]=12'h1af; tr[1]=12'h1be; tr[2]=12'h92f; tr[3]=12'h93e;
          tr[4]=12'hd2b; tr[5]=12'hd3a; end
        4'd2: begin tr[0]=12'h16f; tr[1]=12'h17e; tr[2]=12'h52f; tr[3]=12'h53e;
          tr[4]=12'hd27; tr[5]=12'hd36; end
        4'd3: begin tr[0]=12'h16b; tr[1]=12'h17a; tr[2]=12'h52b; tr[3]=12'h53a;
          tr[4]=12'h927; tr[5]=12'h936; end
        4'd4: begin tr[0]=12'h4af; tr[1]=12'h4be; tr[2]=12'h86f; tr[3]=12'h87e;
          tr[4]=12'hc6b; tr[5]=12'hc7a; end
        4'd5: begin tr[0]=12'h0af; tr[1]=12'h0be; tr[2]=12'h82f; tr[3]=12'h83e;
          tr[4]=12'hc2b; tr[5]=12'hc3a; end
        4'd6: begin tr[0]=12'h06f; tr[1]=12'h07e; tr[2]=12'h42f; tr[3]=12'h43e;
          tr[4]=12'hc27; tr[5]=12'hc36; end
        4'd7: begin tr[0]=12'h06b; tr[1]=12'h07a; tr[2]=12'h42b; tr[3]=12'h43a;
          tr[4]=12'h827; tr[5]=12'h836; end
        4'd8: begin tr[0]=12'h49f; tr[1]=12'h4bd; tr[2]=12'h85f; tr[3]=12'h87d;
          tr[4]=12'hc5b; tr[5]=12'hc79; end
        4'd9: begin tr[0]=12'h09f; tr[1]=12'h0bd; tr[2]=12'h81f; tr[3]=12'h83d;
          tr[4]=12'hc1b; tr[5]=12'hc39; end
        4'd10: begin tr[0]=12'h05f; tr[1]=12'h07d; tr[2]=12'h41f; tr[3]=12'h43d;
          tr[4]=12'hc17; tr[5]=12'hc35; end
        4'd11: begin tr[0]=12'h05b; tr[1]=12'h079; tr[2]=12'h41b; tr[3]=12'h439;
          tr[4]=12'h817; tr[5]=12'h835; end
        4'd12: begin tr[0]=12'h49e; tr[1]=12'h4ad; tr[2]=12'h85e; tr[3]=12'h86d;
          tr[4]=12'hc5a; tr[5]=12'hc69; end
        4'd13: begin tr[0]=12'h09e; tr[1]=12'h0ad; tr[2]=12'h81e; tr[3]=12'h82d;
          tr[4]=12'hc1a; tr[5]=12'hc29; end
        4'd14: begin tr[0]=12'h05e; tr[1]=12'h06d; tr[2]=12'h41e; tr[3]=12'h42d;
          tr[4]=12'hc16; tr[5]=12'hc25; end
        default: begin tr[0]=12'h05a; tr[1]=12'h069; tr[2]=12'h41a; tr[3]=12'h429;
          tr[4]=12'h816; tr[5]=12'h825; end
      endcase
      case (t)
        3'd0: row = tr[0];
        3'd1: row = tr[1];
        3'd2: row = tr[2];
        3'd3: row = tr[3];
        3'd4: row = tr[4];
        default: row = tr[5];
      endcase
      case (f)
        2'd0: cof_idx = row[11:8];
        2'd1: cof_idx = row[7:4];
        default: cof_idx = row[3:0];
      endcase
    end
  endfunction

  // Saturate a 2*EW+1 bit signed value to EW bits.
  function automatic val_t sat_w(input logic signed [2*EW:0] v, output logic ovf);
    logic signed [2*EW:0] vmax;
    logic signed [2*EW:0] vmin;
    begin
      vmax = (2*EW+1)'({1'b0, {(EW-1){1'b1}}});
      vmin = -vmax - (2*EW+1)'(1);
      ovf = 1'b0;
      if (v > vmax) begin
        ovf = 1'b1; sat_w = {1'b0, {(EW-1){1'b1}}};
      end else if (v < vmin) begin
        ovf = 1'b1; sat_w = {1'b1, {(EW-1){1'b0}}};
      end else begin
        sat_w = v[EW-1:0];
      end
    end
  endfunction

endpackage

### design/mi4_ram.sv
//------------------------------------------------------------------------------
// mi4_ram
// Generic single write port RAM with one registered read port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/mi4_front.sv
//------------------------------------------------------------------------------
// mi4_front
// Accepts element beats, writes them to the store and queues a run on index 15.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mi4_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mi4_pkg::val_t   in_element_value,
  input  mi4_pkg::idx_t   in_element_index,
  output logic            st_we,
  output mi4_pkg::idx_t   st_waddr,
  output mi4_pkg::val_t   st_wdata,
  output logic            q_valid,
  input  logic            q_ready,
  output mi4_pkg::run_cmd_t q_cmd
);
  import mi4_pkg::*;

  `include "matrix_inverse_4x4_macros.svh"

  logic [QPW:0] cnt_r, cnt_nxt;
  logic         acc;
  logic         push;
  logic         pop;

  // front stalls while a run is pending so the store stays put for the back
  assign in_ready = (cnt_r == '0);
  assign acc      = in_valid && in_ready;
  assign push     = acc && (in_element_index == idx_t'(IW'(15)));
  assign pop      = q_valid && q_ready;
  assign st_we    = acc;
  assign st_waddr = in_element_index;
  assign st_wdata = in_element_value;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd.dummy = 1'b1;

  // run queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  `MI_ASSERT_IMP(a_no_ovf, push, cnt_r < (QPW+1)'(QDEPTH), "run queue overflow")
  `MI_ASSERT_IMP(a_no_udf, pop, cnt_r != '0, "run queue underflow")
  `MI_ASSERT_NXT(a_push_vis, push && !pop, q_valid, "queued run not visible")
endmodule

### design/mi4_back.sv
//------------------------------------------------------------------------------
// mi4_back
// Sequencer with one shared multiplier: cofactors, determinant, reciprocal
// by restoring division, then sixteen scaled results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mi4_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  mi4_pkg::run_cmd_t q_cmd,
  output mi4_pkg::idx_t     st_raddr,
  input  mi4_pkg::val_t     st_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output mi4_pkg::val_t     out_result_value,
  output mi4_pkg::idx_t     out_result_index,
  output logic              out_last_result,
  output logic              out_singular,
  output logic              out_saturated
);
  import mi4_pkg::*;

  `include "matrix_inverse_4x4_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // issue read of factor
  localparam logic [3:0] S_LAT  = 4'd2;  // read latency
  localparam logic [3:0] S_MUL  = 4'd3;  // multiply
  localparam logic [3:0] S_SAT  = 4'd4;  // saturate product
  localparam logic [3:0] S_ACC  = 4'd5;  // accumulate term
  localparam logic [3:0] S_DRD  = 4'd6;  // determinant row-0 read
  localparam logic [3:0] S_DLAT = 4'd7;
  localparam logic [3:0] S_DMUL = 4'd8;
  localparam logic [3:0] S_DACC = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_OMUL = 4'd11;
  localparam logic [3:0] S_OSAT = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]  st_r, st_nxt;
  logic [3:0]  ent_r, ent_nxt;
  logic [2:0]  trm_r, trm_nxt;
  logic [1:0]  fac_r, fac_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  val_t        cof_r [0:15];
  logic [15:0] cflg_r;
  val_t        prod_r, prod_nxt;      // running product / accumulator operand
  val_t        acc_r, acc_nxt;
  logic        flg_r, flg_nxt;
  logic signed [2*EW-1:0] mul_r, mul_nxt;
  val_t        det_r, det_nxt;
  logic        dflg_r, dflg_nxt;
  val_t        rcp_r, rcp_nxt;
  logic        rflg_r, rflg_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [EW-1:0] dmag_r, dmag_nxt;
  logic        ov_r, ov_nxt;
  val_t        ov_val_r, ov_val_nxt;
  logic        ov_sat_r, ov_sat_nxt;
  logic        ov_sing_r, ov_sing_nxt;
  logic [3:0]  ov_idx_r, ov_idx_nxt;

  logic        cof_we;
  logic signed [2*EW:0] shq;
  logic signed [2*EW:0] sum;
  val_t        sat_v;
  logic        sat_o;
  logic        o;
  logic        odd;
  logic        plus;
  logic [NW:0] trial;
  logic signed [2*EW:0] quo_s;
  logic        det_zero;

  // run is released once the last store read is done, so the store stays put
  assign q_ready = (st_r == S_DACC) && (dcnt_r[1:0] == 2'd3);
  assign odd  = ent_r[2] ^ ent_r[0];
  assign plus = ((trm_r == 3'd0) || (trm_r == 3'd3) || (trm_r == 3'd4)) ^ odd;
  assign det_zero = (det_r == '0);
  // product shifted right, toward zero
  assign shq = (mul_r < 0) ? -((-(2*EW+1)'(mul_r)) >>> FB) : ((2*EW+1)'(mul_r) >>> FB);
  assign trial = {rem_r, 1'b0} - {1'b0, {(NW-EW){1'b0}}, dmag_r};
  assign quo_s = dflg_r ? '0 : '0;

  // store read address
  always_comb begin
    st_raddr = cof_idx(ent_r, trm_r, fac_r);
    if (st_r == S_DRD || st_r == S_DLAT) st_raddr = idx_t'(dcnt_r[1:0]);
  end

  assign out_valid        = ov_r;
  assign out_result_value = ov_val_r;
  assign out_result_index = ov_idx_r;
  assign out_last_result  = (ov_idx_r == 4'd15);
  assign out_singular     = ov_sing_r;
  assign out_saturated    = ov_sat_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; ent_nxt = ent_r; trm_nxt = trm_r; fac_nxt = fac_r;
    dcnt_nxt = dcnt_r; prod_nxt = prod_r; acc_nxt = acc_r; flg_nxt = flg_r;
    mul_nxt = mul_r; det_nxt = det_r; dflg_nxt = dflg_r; rcp_nxt = rcp_r;
    rflg_nxt = rflg_r; rem_nxt = rem_r; quo_nxt = quo_r; dmag_nxt = dmag_r;
    ov_nxt = ov_r; ov_val_nxt = ov_val_r; ov_sat_nxt = ov_sat_r;
    ov_sing_nxt = ov_sing_r; ov_idx_nxt = ov_idx_r;
    cof_we = 1'b0; sum = '0; sat_v = '0; sat_o = 1'b0; o = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (q_valid && q_cmd.dummy) begin
          st_nxt = S_RD; ent_nxt = '0; trm_nxt = '0; fac_nxt = '0;
          acc_nxt = '0; flg_nxt = 1'b0;
        end
      end
      S_RD: st_nxt = S_LAT;
      S_LAT: begin
        if (fac_r == 2'd0) begin
          prod_nxt = st_rdata; fac_nxt = 2'd1; st_nxt = S_RD;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mul_nxt = prod_r * st_rdata;
        st_nxt = S_SAT;
      end
      S_SAT: begin
        sat_v = sat_w(shq, sat_o);
        prod_nxt = sat_v;
        flg_nxt = flg_r | sat_o;
        if (fac_r == 2'd1) begin
          fac_nxt = 2'd2; st_nxt = S_RD;
        end else begin
          st_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum = plus ? ((2*EW+1)'(acc_r) + (2*EW+1)'(prod_r))
                   : ((2*EW+1)'(acc_r) - (2*EW+1)'(prod_r));
        sat_v = sat_w(sum, sat_o);
        o = flg_r | sat_o;
        fac_nxt = '0;
        if (trm_r == 3'd5) begin
          cof_we = 1'b1; acc_nxt = '0; flg_nxt = 1'b0; trm_nxt = '0;
          if (ent_r == 4'd15) begin
            st_nxt = S_DRD; dcnt_nxt = '0; det_nxt = '0; dflg_nxt = 1'b0;
          end else begin
            ent_nxt = ent_r + 1'b1; st_nxt = S_RD;
          end
        end else begin
          acc_nxt = sat_v; flg_nxt = o; trm_nxt = trm_r + 1'b1; st_nxt = S_RD;
        end
      end
      S_DRD: st_nxt = S_DLAT;
      S_DLAT: st_nxt = S_DMUL;
      S_DMUL: begin
        mul_nxt = st_rdata * cof_r[{dcnt_r[1:0], 2'b00}];
        dflg_nxt = dflg_r | cflg_r[{dcnt_r[1:0], 2'b00}];
        st_nxt = S_DACC;
      end
      S_DACC: begin
        prod_nxt = sat_w(shq, sat_o);
        sum = (2*EW+1)'(det_r) + (2*EW+1)'(prod_nxt);
        det_nxt = sat_w(sum, o);
        dflg_nxt = dflg_r | sat_o | o;
        if (dcnt_r[1:0] == 2'd3) begin
          st_nxt = S_DIV;
          dcnt_nxt = '0;
          dmag_nxt = det_nxt[EW-1] ? EW'(-det_nxt) : EW'(det_nxt);
          rem_nxt = '0; quo_nxt = '0;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1; st_nxt = S_DRD;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle of 2^(2*FB), MSB first
        if (dcnt_r == 6'(NW)) begin
          sum = det_r[EW-1] ? -(2*EW+1)'(quo_r) : (2*EW+1)'(quo_r);
          rcp_nxt = sat_w(sum, o);
          rflg_nxt = o & ~det_zero;
          st_nxt = S_OMUL; ent_nxt = '0;
        end else begin
          rem_nxt = {rem_r[NW-2:0], (dcnt_r == 6'(NW-1-2*FB))};
          quo_nxt = {quo_r[NW-2:0], 1'b0};
          if (({rem_r, (dcnt_r == 6'(NW-1-2*FB))} >= {1'b0, {(NW-EW){1'b0}}, dmag_r})
              && !det_zero) begin
            rem_nxt = trial[NW-1:0] | NW'(dcnt_r == 6'(NW-1-2*FB));
            rem_nxt = NW'({rem_r, (dcnt_r == 6'(NW-1-2*FB))}
                          - {1'b0, {(NW-EW){1'b0}}, dmag_r});
            quo_nxt = {quo_r[NW-2:0], 1'b1};
          end
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      S_OMUL: begin
        if (!ov_r || out_ready) begin
          mul_nxt = cof_r[ent_r] * rcp_r;
          st_nxt = S_OSAT;
        end
      end
      S_OSAT: begin
        sat_v = sat_w(shq, sat_o);
        ov_nxt = 1'b1;
        ov_idx_nxt = ent_r;
        ov_sing_nxt = det_zero;
        ov_val_nxt = det_zero ? '0 : sat_v;
        ov_sat_nxt = det_zero ? 1'b0 : (sat_o | cflg_r[ent_r] | dflg_r | rflg_r);
        if (ent_r == 4'd15) begin
          st_nxt = S_OUT;
        end else begin
          ent_nxt = ent_r + 1'b1; st_nxt = S_OMUL;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt; trm_r <= trm_nxt; fac_r <= fac_nxt; dcnt_r <= dcnt_nxt;
    prod_r <= prod_nxt; acc_r <= acc_nxt; flg_r <= flg_nxt; mul_r <= mul_nxt;
    det_r <= det_nxt; dflg_r <= dflg_nxt; rcp_r <= rcp_nxt; rflg_r <= rflg_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; dmag_r <= dmag_nxt;
    ov_val_r <= ov_val_nxt; ov_sat_r <= ov_sat_nxt; ov_sing_r <= ov_sing_nxt;
    ov_idx_r <= ov_idx_nxt;
    if (cof_we) begin
      cof_r[ent_r] <= sat_v;
      cflg_r[ent_r] <= o;
    end
  end

  logic unused_q;
  assign unused_q = quo_s[0];

  `MI_ASSERT_IMP(a_out_hold, out_valid && !out_ready && st_r == S_OSAT, 1'b0,
                 "result overwritten while stalled")
  `MI_ASSERT_IMP(a_rel_ready, q_ready, st_r == S_DACC, "run released too early")
  `MI_ASSERT_NXT(a_start, q_valid && st_r == S_IDLE, st_r == S_RD, "run did not start")
endmodule

### design/matrix_inverse_4x4.sv
//------------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 Q16.16 inverse by adjugate over determinant.
//------------------------------------------------------------------------------
// Elements are loaded one beat each (one beat per cycle while in_ready is high);
// the beat with index 15 starts a run. Every multiply goes through one shared
// 32x32 multiplier fed from a single-read store port, so each of the 96 triple
// products is done as two multiplies plus the accumulate, the determinant is formed
// from row 0, the reciprocal takes one quotient bit per cycle, and the sixteen
// results leave one at a time, each waiting until the previous one is taken.
// Element beats are held off from the index 15 beat until the determinant is
// formed; after that the next matrix may load while the results drain.
`timescale 1ns / 1ps
module matrix_inverse_4x4 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_element_value,
  input  logic [3:0]           in_element_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_result_value,
  output logic [3:0]           out_result_index,
  output logic                 out_last_result,
  output logic                 out_singular,
  output logic                 out_saturated
);
  import mi4_pkg::*;

  logic     st_we;
  idx_t     st_waddr;
  val_t     st_wdata;
  idx_t     st_raddr;
  val_t     st_rdata;
  logic     q_valid;
  logic     q_ready;
  run_cmd_t q_cmd;

  mi4_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_element_value, .in_element_index,
    .st_we, .st_waddr, .st_wdata, .q_valid, .q_ready, .q_cmd
  );

  mi4_ram #(.WIDTH(EW), .DEPTH(16)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  mi4_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .st_raddr, .st_rdata,
    .out_valid, .out_ready, .out_result_value, .out_result_index,
    .out_last_result, .out_singular, .out_saturated
  );
endmodule
